// ===== sv/pni_pkg.sv =====
// ----------------------------------------------------------------------------
// pni_pkg: shared types and constants for the PCM noise injector
// Field widths, generator constants, register indexes, the command passed
// from the front end to the back end, and the back-end sequencer states.
// ----------------------------------------------------------------------------
package pni_pkg;

  localparam int DATA_W      = 8;
  localparam int SAMPLE_W    = 16;
  localparam int RNG_W       = 31;
  localparam int GAIN_W      = 18;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 18;
  localparam int NOISE_SHIFT = 30;

  // default depth of the command queue between front and back
  localparam int CMD_DEPTH = 4;

  // linear congruential generator, modulo 2^31
  localparam logic [RNG_W-1:0] LCG_MUL   = 31'd1103515245;
  localparam logic [RNG_W-1:0] LCG_ADD   = 31'd12345;
  localparam logic [RNG_W-1:0] RNG_RESET = 31'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAIN   = 1'd1;

  // one classified request: a byte to forward, or a full sample to process
  typedef struct packed {
    logic                is_sample;
    logic [SAMPLE_W-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCG,
    ST_SCALE,
    ST_SUM,
    ST_EMIT_LO,
    ST_EMIT_HI
  } back_state_t;

endpackage

// ===== sv/pni_front.sv =====
// ----------------------------------------------------------------------------
// pni_front: input byte pairing
// Accepts bytes, tracks the low/high byte phase, holds the low byte and
// turns each forwarded byte or completed sample into a command for the back end.
// ----------------------------------------------------------------------------
module pni_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [pni_pkg::DATA_W-1:0] data_byte,
  input  logic                       noise_enable,
  input  logic                       cmd_full,
  output logic                       cmd_push,
  output pni_pkg::cmd_t              cmd
);
  import pni_pkg::*;

  logic              accept;
  logic              byte_phase;
  logic [DATA_W-1:0] held_low_byte;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // classify: forward as-is, hold a low byte, or form a sample
  always_comb begin
    cmd_push      = accept && (!noise_enable || byte_phase);
    cmd.is_sample = noise_enable;
    if (noise_enable) begin
      cmd.data = {data_byte, held_low_byte};
    end else begin
      cmd.data = {{(SAMPLE_W-DATA_W){1'b0}}, data_byte};
    end
  end

  // phase counts every byte in both modes
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 1'b0;
      held_low_byte <= '0;
    end else if (accept) begin
      byte_phase <= ~byte_phase;
      if (noise_enable && !byte_phase) begin
        held_low_byte <= data_byte;
      end
    end
  end

endmodule

// ===== sv/pni_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pni_cmd_fifo: command queue
// Small register queue that lets the front end keep taking bytes while the
// back end works on a sample.
// ----------------------------------------------------------------------------
module pni_cmd_fifo #(
  parameter int DEPTH = pni_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pni_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output pni_pkg::cmd_t rd_data,
  output logic          empty
);
  import pni_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== sv/pni_back.sv =====
// ----------------------------------------------------------------------------
// pni_back: noise sequencer and output register
// Forwards plain bytes, and for a sample steps the generator, scales it by
// the gain, adds and saturates, then sends low and high byte.
// ----------------------------------------------------------------------------
module pni_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pni_pkg::GAIN_W-1:0] noise_gain,
  input  logic                       cmd_empty,
  input  pni_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [pni_pkg::DATA_W-1:0] out_byte,
  output logic                       last
);
  import pni_pkg::*;

  localparam int PROD_W  = RNG_W + GAIN_W;
  localparam int NOISE_W = GAIN_W + 2;
  localparam int SUM_W   = SAMPLE_W + 5;
  localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LOW  = -SUM_W'(32767);

  back_state_t                state;
  back_state_t                state_next;
  logic [RNG_W-1:0]           rng_state;
  logic [RNG_W-1:0]           rng_state_next;
  logic signed [SAMPLE_W-1:0] sample;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-1:0]          prod_next;
  logic [SAMPLE_W-1:0]        result;
  logic [SAMPLE_W-1:0]        result_next;
  logic signed [NOISE_W-1:0]  noise;
  logic signed [SUM_W-1:0]    sum;
  logic                       out_valid;
  logic                       out_free;
  logic                       out_load;
  logic [DATA_W-1:0]          out_byte_next;
  logic                       last_next;
  logic                       sample_load;
  logic                       rng_load;
  logic                       prod_load;
  logic                       result_load;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // datapath: generator step, gain multiply, offset/add/saturate
  assign rng_state_next = RNG_W'(rng_state * LCG_MUL) + LCG_ADD;
  assign prod_next = {{GAIN_W{1'b0}}, rng_state} * {{RNG_W{1'b0}}, noise_gain};
  assign noise = $signed({1'b0, prod[PROD_W-1:NOISE_SHIFT]})
               - $signed({2'b00, noise_gain});

  always_comb begin
    sum = SUM_W'(sample) + SUM_W'(noise);
    if (sum > SAT_HIGH) begin
      result_next = SAT_HIGH[SAMPLE_W-1:0];
    end else if (sum < SAT_LOW) begin
      result_next = SAT_LOW[SAMPLE_W-1:0];
    end else begin
      result_next = sum[SAMPLE_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty && cmd.is_sample) begin
          state_next = ST_LCG;
        end
      end
      ST_LCG:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SUM;
      ST_SUM:   state_next = ST_EMIT_LO;
      ST_EMIT_LO: begin
        if (out_free) begin
          state_next = ST_EMIT_HI;
        end
      end
      ST_EMIT_HI: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_pop       = 1'b0;
    out_load      = 1'b0;
    out_byte_next = result[DATA_W-1:0];
    last_next     = 1'b0;
    sample_load   = 1'b0;
    rng_load      = 1'b0;
    prod_load     = 1'b0;
    result_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.is_sample) begin
            cmd_pop     = 1'b1;
            sample_load = 1'b1;
          end else if (out_free) begin
            cmd_pop       = 1'b1;
            out_load      = 1'b1;
            out_byte_next = cmd.data[DATA_W-1:0];
            last_next     = 1'b1;
          end
        end
      end
      ST_LCG:   rng_load    = 1'b1;
      ST_SCALE: prod_load   = 1'b1;
      ST_SUM:   result_load = 1'b1;
      ST_EMIT_LO: begin
        out_load      = out_free;
        out_byte_next = result[DATA_W-1:0];
      end
      ST_EMIT_HI: begin
        out_load      = out_free;
        out_byte_next = result[SAMPLE_W-1:DATA_W];
        last_next     = 1'b1;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rng_state <= RNG_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rng_load) begin
        rng_state <= rng_state_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (sample_load) begin
      sample <= $signed(cmd.data);
    end
    if (prod_load) begin
      prod <= prod_next;
    end
    if (result_load) begin
      result <= result_next;
    end
    if (out_load) begin
      out_byte <= out_byte_next;
      last     <= last_next;
    end
  end

endmodule

// ===== sv/pcm_noise_injector.sv =====
// ----------------------------------------------------------------------------
// pcm_noise_injector: uniform noise on a 16-bit little-endian PCM byte stream
// Pairs bytes into samples, adds scaled generator noise, saturates to
// +-32767 and returns the sample as two bytes, low byte first.
// ----------------------------------------------------------------------------
// With noise off, every byte is forwarded and the block sustains one byte
// per cycle while pop is held high. With noise on, the low byte is held
// and the high byte forms a sample that the back-end sequencer steps
// through queue pop, generator multiply, gain multiply, add and saturate,
// then the low and high output bytes through the single output register;
// it pops no new command until both bytes are out. The front end keeps
// accepting bytes into a CMD_DEPTH-entry command queue while the back end is
// busy; full rises when that queue fills. Configuration is taken on any
// cycle with cfg_write high; writes belong between streams.
// ----------------------------------------------------------------------------
module pcm_noise_injector #(
  parameter int CMD_DEPTH = pni_pkg::CMD_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [pni_pkg::DATA_W-1:0]     data_byte,
  output logic                           empty,
  input  logic                           pop,
  output logic [pni_pkg::DATA_W-1:0]     out_byte,
  output logic                           last,
  input  logic                           cfg_write,
  input  logic [pni_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pni_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pni_pkg::*;

  logic              noise_enable;
  logic [GAIN_W-1:0] noise_gain;
  logic              cmd_push;
  logic              cmd_pop;
  logic              cmd_full;
  logic              cmd_empty;
  cmd_t              cmd_in;
  cmd_t              cmd_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_enable <= 1'b0;
      noise_gain   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NOISE_ENABLE: noise_enable <= cfg_data[0];
        CFG_NOISE_GAIN:   noise_gain   <= cfg_data[GAIN_W-1:0];
        default:          noise_enable <= noise_enable;
      endcase
    end
  end

  pni_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .noise_enable (noise_enable),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  pni_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  pni_back u_back (
    .clk        (clk),
    .rst        (rst),
    .noise_gain (noise_gain),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .last       (last)
  );

  // front never writes a full command queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command queue written while full");

  // back never pops an empty command queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command queue read while empty");

  // with noise off, every accepted byte becomes a request to the back end
  a_bypass_forwards: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !noise_enable) |-> cmd_push)
    else $error("bypass byte not forwarded");

endmodule

// ===== verif/tb_pcm_noise_injector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_noise_injector: self-checking bench for the PCM noise injector
// Streams audio bytes through the push/full side and drains results through
// the empty/pop side. An in-bench predictor computes each expected output
// byte from the generator and configuration. Directed corner cases run
// first, then random sample streams under several register settings and
// varying backpressure on both sides.
// ----------------------------------------------------------------------------
module tb_pcm_noise_injector;
  import pni_pkg::*;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int SAT_MAX        = 32767;
  localparam int N_PHASES       = 9;
  localparam int PAIRS_PER_HALF = 20;
  localparam int MAX_PRINTS     = 50;

  // one output byte as the block should present it
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              is_last;
  } pcm_byte_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  pop       = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [DATA_W-1:0]     data_byte = '0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  full;
  logic                  empty;
  logic                  last;
  logic [DATA_W-1:0]     out_byte;

  // predictor copy of registers and state
  logic              en_reg;
  logic [GAIN_W-1:0] gain_reg;
  logic [RNG_W-1:0]  lcg_seed;
  logic              hi_next;
  logic [DATA_W-1:0] low_hold;

  logic [DATA_W-1:0] audio_q[$];
  pcm_byte_t         noisy_q[$];
  int                bytes_queued  = 0;
  int                bytes_taken   = 0;
  int                mismatches    = 0;
  int                cycles        = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  logic              in_taken      = 1'b0;

  pcm_noise_injector i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
  endtask

  // advance the predictor by one accepted byte, queue the bytes it yields
  function automatic void inject_noise(input logic [DATA_W-1:0] b);
    logic [63:0]          prod;
    logic signed [15:0]   raw;
    longint               smp;
    longint               nz;
    longint               noisy;
    logic [SAMPLE_W-1:0]  word;
    if (!en_reg) begin
      hi_next = ~hi_next;
      noisy_q.push_back('{data: b, is_last: 1'b1});
    end else if (!hi_next) begin
      low_hold = b;
      hi_next  = 1'b1;
    end else begin
      hi_next  = 1'b0;
      prod     = 64'(lcg_seed) * 64'(LCG_MUL) + 64'(LCG_ADD);
      lcg_seed = prod[RNG_W-1:0];
      // floor((seed - 2^30) * gain / 2^30) computed on nonnegative terms
      prod  = 64'(lcg_seed) * 64'(gain_reg);
      nz    = longint'(prod >> NOISE_SHIFT) - longint'(gain_reg);
      raw   = {b, low_hold};
      smp   = raw;
      noisy = smp + nz;
      if (noisy > SAT_MAX) noisy = SAT_MAX;
      if (noisy < -SAT_MAX) noisy = -SAT_MAX;
      word  = noisy[SAMPLE_W-1:0];
      noisy_q.push_back('{data: word[7:0], is_last: 1'b0});
      noisy_q.push_back('{data: word[15:8], is_last: 1'b1});
    end
  endfunction

  // bus monitor: register writes, accepted requests, returned bytes
  always @(posedge clk) begin : monitor
    pcm_byte_t want;
    if (rst) begin
      en_reg      = 1'b0;
      gain_reg    = '0;
      lcg_seed    = RNG_RESET;
      hi_next     = 1'b0;
      low_hold    = '0;
      in_taken    = 1'b0;
      bytes_taken = 0;
      noisy_q.delete();
    end else begin
      if (pop && !empty) begin
        if (noisy_q.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b", out_byte, last));
        end else begin
          want = noisy_q.pop_front();
          if (out_byte !== want.data)
            report($sformatf("out_byte got %02h want %02h", out_byte, want.data));
          if (last !== want.is_last)
            report($sformatf("last got %0b want %0b", last, want.is_last));
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_NOISE_ENABLE) en_reg = cfg_data[0];
        else if (cfg_index == CFG_NOISE_GAIN) gain_reg = cfg_data[GAIN_W-1:0];
      end
      in_taken = push && !full;
      if (in_taken) begin
        inject_noise(data_byte);
        bytes_taken++;
      end
    end
  end

  // request driver and result drain, both updated on the falling edge
  always @(negedge clk) begin : driver
    logic send;
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (in_taken) void'(audio_q.pop_front());
      send = (audio_q.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
      push <= send;
      if (send) data_byte <= audio_q[0];
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycles = cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_pcm_noise_injector: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic void add_byte(input logic [DATA_W-1:0] b);
    audio_q.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void add_pair(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    add_byte(lo);
    add_byte(hi);
  endfunction

  // wait until every request is taken and every byte returned, then let
  // the block idle; a held low byte stays held in the front end
  task automatic settle();
    @(negedge clk);
    while (bytes_taken != bytes_queued || noisy_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 31);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    if (sel == 2) return 8'h7f;
    if (sel == 3) return 8'h80;
    return DATA_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input int p);
    if (p == 0) return '1;
    if (p == 1) return '0;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_W'(1);
      2:       return '1;
      3:       return GAIN_W'($urandom_range(0, 2000));
      4:       return GAIN_W'($urandom_range(0, 40000));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // one register setting, two bursts of mostly paired bytes with a full
  // drain between them
  task automatic run_phase(input int p);
    logic [CFG_DATA_W-1:0] en_word;
    logic [GAIN_W-1:0]     g;
    int                    half;
    if (p < 3) begin
      send_idle_pct = 21;
      recv_idle_pct = 86;
    end else if (p < 6) begin
      send_idle_pct = 86;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    en_word    = CFG_DATA_W'($urandom);
    en_word[0] = (p == 3 || p == 7) ? 1'b0 : (p == 5) ? 1'($urandom_range(0, 1)) : 1'b1;
    g          = pick_gain(p);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_NOISE_ENABLE, en_word);
      write_reg(CFG_NOISE_GAIN, g);
    end else begin
      write_reg(CFG_NOISE_GAIN, g);
      write_reg(CFG_NOISE_ENABLE, en_word);
    end
    for (half = 0; half < 2; half++) begin
      @(posedge clk);
      repeat (PAIRS_PER_HALF) begin
        // an occasional stray byte breaks the low/high pairing
        if ($urandom_range(0, 99) < 6) add_byte(pick_byte());
        add_pair(pick_byte(), pick_byte());
      end
      settle();
    end
  endtask

  initial begin : sequencer
    int p;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 86;

    // noise off: bytes pass through, phase still toggles
    @(posedge clk);
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h80);
    settle();

    // noise on, zero gain: first byte is a high byte paired with the reset
    // low byte; then clamping of -32768 and the positive extreme
    write_reg(CFG_NOISE_ENABLE, 18'h00001);
    @(posedge clk);
    add_byte(8'h7f);
    add_pair(8'h00, 8'h80);
    add_pair(8'hff, 8'h7f);
    add_pair(8'hff, 8'hff);
    settle();

    // full-scale gain drives saturation at both ends
    write_reg(CFG_NOISE_GAIN, '1);
    @(posedge clk);
    add_pair(8'hff, 8'h7f);
    add_pair(8'h00, 8'h80);
    add_pair(8'h00, 8'h00);
    add_pair(8'h01, 8'h80);
    settle();

    // enable write with upper bits set: only bit 0 counts, so noise goes off
    write_reg(CFG_NOISE_ENABLE, 18'h3fffe);
    @(posedge clk);
    add_byte(8'h55);
    settle();

    // re-enable mid-sample: high byte pairs with the stale held low byte
    write_reg(CFG_NOISE_ENABLE, 18'h2aaab);
    @(posedge clk);
    add_byte(8'haa);
    settle();

    write_reg(CFG_NOISE_GAIN, 18'h00001);
    @(posedge clk);
    add_pair(8'h34, 8'h12);
    settle();

    for (p = 0; p < N_PHASES; p++) run_phase(p);

    if (mismatches == 0) $display("tb_pcm_noise_injector: done, clean");
    else $display("tb_pcm_noise_injector: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pni_pkg.sv
sv/pni_front.sv
sv/pni_cmd_fifo.sv
sv/pni_back.sv
sv/pcm_noise_injector.sv
verif/tb_pcm_noise_injector.sv
